>>> sv/bfdc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and mode codes for the ballast fill/drain controller.
// No dependencies; every other file of the block imports this package.
package bfdc_pkg;

   localparam int TIME_W  = 32;          // millisecond timestamps and fill time
   localparam int QUO_W   = 18;          // per-tick level step, at most 200000
   localparam int NUM_W   = TIME_W + QUO_W;
   localparam int MILLI_W = 18;          // level in thousandths, signed
   localparam int LEVEL_W = 8;           // level and target in whole units, signed
   localparam int MODE_W  = 2;
   localparam int REQ_DATA_W = 40;       // now_ms + target_level
   localparam int RSP_DATA_W = 24;       // 19 payload bits padded to three bytes

   localparam logic [TIME_W-1:0]  FILL_TIME_RESET = TIME_W'(10000);
   localparam logic [QUO_W-1:0]   RANGE_MILLI     = QUO_W'(200000);

   // Reciprocal of 1000 scaled by 2**27, exact for magnitudes below 2**17.
   localparam int                 RECIP_SHIFT = 27;
   localparam logic [QUO_W-1:0]   RECIP_1000  = QUO_W'(134218);

   localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FILL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd2;
   localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd3;

   localparam logic signed [LEVEL_W-1:0] PUMP_FILL  = 8'sd100;
   localparam logic signed [LEVEL_W-1:0] PUMP_DRAIN = -8'sd100;
   localparam logic signed [LEVEL_W-1:0] PUMP_OFF   = 8'sd0;

   typedef logic signed [MILLI_W-1:0] milli_type;
   typedef logic signed [LEVEL_W-1:0] level_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> sv/bfdc_divider.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
// Depends on bfdc_pkg; the quotient must fit in QUO_W bits (numer < denom * 2**QUO_W).
module bfdc_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bfdc_pkg::NUM_W-1:0]  numer,
   input  logic [bfdc_pkg::TIME_W-1:0] denom,
   output bfdc_pkg::div_rsp_type       rsp
);
   import bfdc_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0]  low_ff, low_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [TIME_W:0]   trial;
   logic [TIME_W:0]   diff;
   logic              fits;

   // The partial remainder stays below the divisor, so one extra bit holds the shifted value.
   assign trial = {rem_ff, low_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(QUO_W);
         rem_in   = numer[NUM_W-1:QUO_W];
         low_in   = numer[QUO_W-1:0];
         den_in   = denom;
         quo_in   = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         low_in   = {low_ff[QUO_W-2:0], 1'b0};
         quo_in   = {quo_ff[QUO_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> sv/ballast_fill_drain_controller.sv
`timescale 1ns / 1ps
// Top level of the ballast fill/drain controller: mode sequencer and level estimate.
// Depends on bfdc_pkg and bfdc_divider.
//
// Usage:
//   Each transaction on the req_ channel is one control tick carrying the current
//   millisecond time and the wanted ballast level. Every tick yields exactly one
//   transaction on the rsp_ channel with pump speed, vent valve, mode and the
//   estimated level in whole units. The csr_ port writes the fill time (ms for
//   the full 200-unit travel); write it only while no tick is in flight.
//
//   A tick in idle or holding mode, or the first timed tick after a fill or
//   drain starts, goes from acceptance to the mode decision and then to the
//   output register. A tick that moves the level estimate first passes through
//   the multiply, the one-bit-per-cycle divider that scales elapsed time by the
//   fill time, the level update and the scaling to whole units. A zero fill
//   time skips the divider and goes straight to the level update. req_tready is
//   high only while the sequencer waits for a tick, so one tick is in flight at
//   a time. A finished result sits in the output register, and the next tick is
//   accepted while it waits; a second result then waits in the sequencer until
//   the receiver takes the first.
//
//   Reset (synchronous, active high) returns the block to idle mode with a zero
//   level, no recorded timestamp, a fill time of 10000 ms and no result pending.
module ballast_fill_drain_controller (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration: fill time in milliseconds.
   input  logic                            csr_wen,
   input  logic [bfdc_pkg::TIME_W-1:0]     csr_wdata,
   // Ticks. tdata, from bit 0: now_ms[31:0], wanted_level[39:32].
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bfdc_pkg::REQ_DATA_W-1:0] req_tdata,
   // Results. tdata, from bit 0: pump_speed[7:0], valve_open[8], mode[10:9],
   // level_est[18:11], zero padding[23:19].
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfdc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bfdc_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a tick
   localparam logic [2:0] ST_MUL   = 3'd1;  // elapsed time times 200000
   localparam logic [2:0] ST_DIVGO = 3'd2;  // launch the divider
   localparam logic [2:0] ST_DIV   = 3'd3;  // wait for the quotient
   localparam logic [2:0] ST_UPD   = 3'd4;  // apply the step and saturate
   localparam logic [2:0] ST_SCALE = 3'd5;  // thousandths to whole units
   localparam logic [2:0] ST_CMP   = 3'd6;  // mode decision and result
   localparam logic [2:0] ST_OUT   = 3'd7;  // hand the result to the output register

   localparam logic signed [MILLI_W+1:0] MILLI_MAX = 20'sd100000;
   localparam logic signed [MILLI_W+1:0] MILLI_MIN = -20'sd100000;
   localparam logic signed [MILLI_W-1:0] MILLI_PER_UNIT = 18'sd1000;
   localparam level_type LEVEL_MAX = 8'sd100;
   localparam level_type LEVEL_MIN = -8'sd100;
   localparam logic signed [LEVEL_W:0] TOL_START = 9'sd5;
   localparam logic signed [LEVEL_W:0] TOL_LEAVE = 9'sd10;

   logic [2:0]            state_ff, state_in;
   logic [TIME_W-1:0]     fill_time_ff, fill_time_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   milli_type             level_milli_ff, level_milli_in;
   level_type             level_whole_ff, level_whole_in;
   logic [TIME_W-1:0]     last_time_ff, last_time_in;
   level_type             tgt_ff, tgt_in;
   logic [TIME_W-1:0]     dt_ff, dt_in;
   logic [NUM_W-1:0]      product_ff, product_in;
   logic [QUO_W-1:0]      delta_ff, delta_in;
   logic [RSP_DATA_W-1:0] res_ff, res_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                  div_start;
   div_rsp_type           div_rsp;

   level_type             raw_tgt;
   level_type             clamped_tgt;
   logic [TIME_W-1:0]     req_now;
   logic [TIME_W-1:0]     elapsed;
   logic signed [MILLI_W+1:0] step_sum;
   logic [MILLI_W-2:0]    milli_mag;
   logic [MILLI_W+QUO_W-2:0] scaled;
   level_type             whole_mag;
   logic signed [LEVEL_W:0] err;
   logic                  err_big;
   logic                  err_huge;
   level_type             pump;
   logic                  valve;

   bfdc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (product_ff),
      .denom (fill_time_ff),
      .rsp   (div_rsp)
   );

   assign div_start = (state_ff == ST_DIVGO);

   // Input decode: clamp the target and measure elapsed time (wraps modulo 2**32).
   assign req_now     = req_tdata[TIME_W-1:0];
   assign raw_tgt     = req_tdata[TIME_W+LEVEL_W-1:TIME_W];
   assign clamped_tgt = (raw_tgt < LEVEL_MIN) ? LEVEL_MIN :
                        (raw_tgt > LEVEL_MAX) ? LEVEL_MAX : raw_tgt;
   assign elapsed     = req_now - last_time_ff;

   // Level step with room for one full-range step beyond the limits.
   assign step_sum = (mode_ff == MODE_DRAIN) ?
                     (MILLI_W+2)'(level_milli_ff) - $signed({2'b00, delta_ff}) :
                     (MILLI_W+2)'(level_milli_ff) + $signed({2'b00, delta_ff});

   // Truncation toward zero: divide the magnitude by 1000 through the reciprocal.
   assign milli_mag = level_milli_ff[MILLI_W-1] ? (MILLI_W-1)'(-level_milli_ff) :
                                                  level_milli_ff[MILLI_W-2:0];
   assign scaled    = (MILLI_W+QUO_W-1)'(milli_mag) * (MILLI_W+QUO_W-1)'(RECIP_1000);
   assign whole_mag = LEVEL_W'(scaled >> RECIP_SHIFT);

   // Error between target and the current whole-unit estimate.
   assign err      = (LEVEL_W+1)'(tgt_ff) - (LEVEL_W+1)'(level_whole_ff);
   assign err_big  = (err > TOL_START) || (err < -TOL_START);
   assign err_huge = (err > TOL_LEAVE) || (err < -TOL_LEAVE);

   always_comb begin
      state_in       = state_ff;
      fill_time_in   = fill_time_ff;
      mode_in        = mode_ff;
      level_milli_in = level_milli_ff;
      level_whole_in = level_whole_ff;
      last_time_in   = last_time_ff;
      tgt_in         = tgt_ff;
      dt_in          = dt_ff;
      product_in     = product_ff;
      delta_in       = delta_ff;
      res_in         = res_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      pump           = PUMP_OFF;
      valve          = 1'b0;

      if (csr_wen) begin
         fill_time_in = csr_wdata;
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               tgt_in   = clamped_tgt;
               delta_in = '0;
               state_in = ST_CMP;
               if ((mode_ff == MODE_FILL) || (mode_ff == MODE_DRAIN)) begin
                  // The first tick after a start only records its timestamp.
                  last_time_in = req_now;
                  if (last_time_ff != '0) begin
                     dt_in    = (elapsed > fill_time_ff) ? fill_time_ff : elapsed;
                     state_in = (fill_time_ff == '0) ? ST_UPD : ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            product_in = NUM_W'(dt_ff) * NUM_W'(RANGE_MILLI);
            state_in   = ST_DIVGO;
         end
         ST_DIVGO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               delta_in = div_rsp.quotient;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (step_sum > MILLI_MAX) begin
               level_milli_in = MILLI_MAX[MILLI_W-1:0];
            end else if (step_sum < MILLI_MIN) begin
               level_milli_in = MILLI_MIN[MILLI_W-1:0];
            end else begin
               level_milli_in = step_sum[MILLI_W-1:0];
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            level_whole_in = level_milli_ff[MILLI_W-1] ? -whole_mag : whole_mag;
            state_in       = ST_CMP;
         end
         ST_CMP: begin
            case (mode_ff)
               MODE_IDLE: begin
                  if (err_big) begin
                     last_time_in = '0;
                     if (err > 0) begin
                        mode_in = MODE_FILL;
                        pump    = PUMP_FILL;
                     end else begin
                        mode_in = MODE_DRAIN;
                        pump    = PUMP_DRAIN;
                        valve   = 1'b1;
                     end
                  end
               end
               MODE_FILL: begin
                  pump = PUMP_FILL;
                  if (level_whole_ff >= tgt_ff) begin
                     level_whole_in = tgt_ff;
                     level_milli_in = MILLI_W'(tgt_ff) * MILLI_PER_UNIT;
                     mode_in        = MODE_HOLD;
                  end
               end
               MODE_DRAIN: begin
                  pump  = PUMP_DRAIN;
                  valve = 1'b1;
                  if (level_whole_ff <= tgt_ff) begin
                     level_whole_in = tgt_ff;
                     level_milli_in = MILLI_W'(tgt_ff) * MILLI_PER_UNIT;
                     mode_in        = MODE_HOLD;
                  end
               end
               default: begin
                  if (err_huge) begin
                     mode_in = MODE_IDLE;
                  end
               end
            endcase
            res_in   = {5'b0, level_whole_in, mode_in, valve, pump};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fill_time_ff   <= FILL_TIME_RESET;
         mode_ff        <= MODE_IDLE;
         level_milli_ff <= '0;
         level_whole_ff <= '0;
         last_time_ff   <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_time_ff   <= fill_time_in;
         mode_ff        <= mode_in;
         level_milli_ff <= level_milli_in;
         level_whole_ff <= level_whole_in;
         last_time_ff   <= last_time_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
      tgt_ff       <= tgt_in;
      dt_ff        <= dt_in;
      product_ff   <= product_in;
      delta_ff     <= delta_in;
      res_ff       <= res_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

>>> sv/bfdc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ballast fill/drain controller, bound to the top level.
// Depends on bfdc_pkg for the mode codes and pump levels.
module bfdc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bfdc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bfdc_pkg::*;

   logic [LEVEL_W-1:0] pump;
   logic               valve;
   logic [MODE_W-1:0]  mode;

   assign pump  = rsp_tdata[LEVEL_W-1:0];
   assign valve = rsp_tdata[LEVEL_W];
   assign mode  = rsp_tdata[LEVEL_W+MODE_W:LEVEL_W+1];

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The vent valve opens only together with the drain pump, while draining or on the
   // tick that ends a drain in holding mode.
   a_valve_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && valve |-> pump == PUMP_DRAIN &&
         (mode == MODE_DRAIN || mode == MODE_HOLD))
      else $error("valve open without draining");

   // Idle mode never drives the pump or the valve.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mode == MODE_IDLE |-> pump == PUMP_OFF && !valve)
      else $error("pump or valve active while idle");

   // Filling always reports the fill pump with the valve shut.
   a_fill_pump: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mode == MODE_FILL |-> pump == PUMP_FILL && !valve)
      else $error("filling without fill pump");

endmodule

bind ballast_fill_drain_controller bfdc_checker u_bfdc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
